// File: rtl/cstk_pkg.sv
// ---------------------------------------------------------------------------
// cstk_pkg
// Shared widths, register codes and pipeline side-band types for the
// constant strain triangle stiffness block.
// ---------------------------------------------------------------------------
`default_nettype none

package cstk_pkg;

    // input and derived operand widths
    localparam int COORD_W = 32;          // Q16.16 coordinate, register, thickness
    localparam int DIFF_W  = 33;          // coordinate difference (b, c terms)
    localparam int PROD_W  = 66;          // product of two differences
    localparam int AREA_W  = 65;          // magnitude of twice the area
    localparam int DEN_W   = 66;          // divisor, twice the magnitude above
    localparam int THICK_W = 31;          // positive thickness after repair
    localparam int SUM_W   = 100;         // signed B'^T D B' entry before scaling
    localparam int MAG_W   = 99;          // magnitude of that entry
    localparam int NUM_W   = 131;         // scaled, rounded dividend
    localparam int Q_W     = 64;          // quotient bits kept
    localparam int IDX_W   = 3;           // matrix row / column index
    localparam int CFG_W   = 2;           // register index width

    localparam logic [IDX_W-1:0] LAST_IDX = 3'd5;

    // configuration register indexes
    localparam logic [CFG_W-1:0] CFG_D_XX    = 2'd0;
    localparam logic [CFG_W-1:0] CFG_D_XY    = 2'd1;
    localparam logic [CFG_W-1:0] CFG_D_YY    = 2'd2;
    localparam logic [CFG_W-1:0] CFG_D_SHEAR = 2'd3;

    // register reset values, Q16.16
    localparam logic [COORD_W-1:0] RST_D_XX    = 32'h0001_0000;
    localparam logic [COORD_W-1:0] RST_D_XY    = 32'h0000_0000;
    localparam logic [COORD_W-1:0] RST_D_YY    = 32'h0001_0000;
    localparam logic [COORD_W-1:0] RST_D_SHEAR = 32'h0000_8000;

    // thickness used when the request carries zero or less
    localparam logic [THICK_W-1:0] ONE_Q16 = 31'h0001_0000;

    // saturation ends of the result
    localparam logic [Q_W-1:0] VAL_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [Q_W-1:0] VAL_MIN = 64'h8000_0000_0000_0000;

    // side band that travels with every matrix entry
    typedef struct packed {
        logic             valid;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        logic             last;
        logic             degen;
    } t_ctl;

    // per-element scale factors that travel with every matrix entry
    typedef struct packed {
        logic [AREA_W-1:0]  area;
        logic [DEN_W-1:0]   den;
        logic [THICK_W-1:0] thick;
    } t_elem;

endpackage

`default_nettype wire

// File: rtl/cst_triangle_stiffness.sv
// ---------------------------------------------------------------------------
// cst_triangle_stiffness
// Plane constant strain triangle: takes three nodes and a thickness and
// streams the 21 upper-triangle entries of t/(4|A|) * B'^T D B', Q32.32,
// rounded half away from zero and saturated.
// ---------------------------------------------------------------------------
//  channel  | direction | payload                                  | handshake
//  s        | in        | x1 y1 x2 y2 x3 y3 thickness (7 x 32)     | tvalid/tready
//  m        | out       | row, col, entry (tdata); degenerate;last | tvalid/tready
//  cfg      | in        | d_xx d_xy d_yy d_shear by index          | write enable
//
//  One entry leaves per cycle while the result port is not held, so an element
//  holds the result port for its 21 entries; the result port is the throughput
//  limit. With the pipeline empty, an accepted request passes the request
//  register, three front stages, the element register, eight multiply/add
//  stages, an overflow test stage, 64 restoring divider stages (one quotient
//  bit per stage) and the output register before its first entry is
//  presented. Reset (synchronous, active low) clears valid bits and loads the
//  D registers with their defaults. A held result freezes the entry pipeline;
//  the front stages keep taking requests until they fill.
// ---------------------------------------------------------------------------
`default_nettype none

module cst_triangle_stiffness (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    // slave side
    input  wire logic         i_s_tvalid,
    output logic              o_s_tready,
    // [31:0] x_one, [63:32] y_one, [95:64] x_two, [127:96] y_two,
    // [159:128] x_three, [191:160] y_three, [223:192] thickness
    input  wire logic [223:0] i_s_tdata,
    // master side
    output logic              o_m_tvalid,
    input  wire logic         i_m_tready,
    // [2:0] row_index, [5:3] col_index, [69:6] entry_value, [71:70] zero
    output logic [71:0]       o_m_tdata,
    // [0] degenerate
    output logic              o_m_tuser,
    // last_entry
    output logic              o_m_tlast,
    // configuration
    input  wire logic         i_cfg_we,
    input  wire logic [1:0]   i_cfg_idx,
    input  wire logic [31:0]  i_cfg_data
);
    import cstk_pkg::*;

    // ---------------- configuration registers ----------------
    logic signed [COORD_W-1:0] r_d_xx, r_d_xy, r_d_yy, r_d_shear;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_xx    <= RST_D_XX;
            r_d_xy    <= RST_D_XY;
            r_d_yy    <= RST_D_YY;
            r_d_shear <= RST_D_SHEAR;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_D_XX:    r_d_xx    <= i_cfg_data;
                CFG_D_XY:    r_d_xy    <= i_cfg_data;
                CFG_D_YY:    r_d_yy    <= i_cfg_data;
                CFG_D_SHEAR: r_d_shear <= i_cfg_data;
                default:     r_d_xx    <= r_d_xx;
            endcase
        end
    end

    // ---------------- flow control ----------------
    logic r_out_valid;
    logic r_f1_valid, r_f2_valid, r_f3_valid, r_f4_valid, r_el_valid;
    logic [IDX_W-1:0] r_row, r_col;
    logic w_en, w_last_emit, w_el_take;
    logic w_rdy1, w_rdy2, w_rdy3, w_rdy4;

    // entry pipeline moves unless a result is held at the port
    assign w_en        = !r_out_valid || i_m_tready;
    assign w_last_emit = (r_row == LAST_IDX);
    assign w_el_take   = w_en && (!r_el_valid || w_last_emit);
    assign w_rdy4      = !r_f4_valid || w_el_take;
    assign w_rdy3      = !r_f3_valid || w_rdy4;
    assign w_rdy2      = !r_f2_valid || w_rdy3;
    assign w_rdy1      = !r_f1_valid || w_rdy2;
    assign o_s_tready  = w_rdy1;

    // ---------------- F1: request register ----------------
    logic signed [COORD_W-1:0] r_f1_x [3];
    logic signed [COORD_W-1:0] r_f1_y [3];
    logic signed [COORD_W-1:0] r_f1_t;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_valid <= 1'b0;
        end else if (w_rdy1) begin
            r_f1_valid <= i_s_tvalid;
        end
        if (w_rdy1) begin
            r_f1_x[0] <= i_s_tdata[31:0];
            r_f1_y[0] <= i_s_tdata[63:32];
            r_f1_x[1] <= i_s_tdata[95:64];
            r_f1_y[1] <= i_s_tdata[127:96];
            r_f1_x[2] <= i_s_tdata[159:128];
            r_f1_y[2] <= i_s_tdata[191:160];
            r_f1_t    <= i_s_tdata[223:192];
        end
    end

    // ---------------- F2: node differences, thickness repair ----------------
    logic signed [DIFF_W-1:0] r_f2_b [3];
    logic signed [DIFF_W-1:0] r_f2_c [3];
    logic [THICK_W-1:0]       r_f2_t;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f2_valid <= 1'b0;
        end else if (w_rdy2) begin
            r_f2_valid <= r_f1_valid;
        end
        if (w_rdy2) begin
            r_f2_b[0] <= DIFF_W'(r_f1_y[1]) - DIFF_W'(r_f1_y[2]);
            r_f2_b[1] <= DIFF_W'(r_f1_y[2]) - DIFF_W'(r_f1_y[0]);
            r_f2_b[2] <= DIFF_W'(r_f1_y[0]) - DIFF_W'(r_f1_y[1]);
            r_f2_c[0] <= DIFF_W'(r_f1_x[2]) - DIFF_W'(r_f1_x[1]);
            r_f2_c[1] <= DIFF_W'(r_f1_x[0]) - DIFF_W'(r_f1_x[2]);
            r_f2_c[2] <= DIFF_W'(r_f1_x[1]) - DIFF_W'(r_f1_x[0]);
            r_f2_t    <= (r_f1_t <= 0) ? ONE_Q16 : r_f1_t[THICK_W-1:0];
        end
    end

    // ---------------- F3: area products ----------------
    // 2A = c2*b1 - c1*b2
    logic signed [DIFF_W-1:0] r_f3_b [3];
    logic signed [DIFF_W-1:0] r_f3_c [3];
    logic [THICK_W-1:0]       r_f3_t;
    logic signed [PROD_W-1:0] r_f3_pa, r_f3_pb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f3_valid <= 1'b0;
        end else if (w_rdy3) begin
            r_f3_valid <= r_f2_valid;
        end
        if (w_rdy3) begin
            r_f3_b  <= r_f2_b;
            r_f3_c  <= r_f2_c;
            r_f3_t  <= r_f2_t;
            r_f3_pa <= r_f2_c[2] * r_f2_b[1];
            r_f3_pb <= r_f2_c[1] * r_f2_b[2];
        end
    end

    // ---------------- F4: signed twice-area ----------------
    logic signed [DIFF_W-1:0] r_f4_b [3];
    logic signed [DIFF_W-1:0] r_f4_c [3];
    logic [THICK_W-1:0]       r_f4_t;
    logic signed [PROD_W-1:0] r_f4_a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f4_valid <= 1'b0;
        end else if (w_rdy4) begin
            r_f4_valid <= r_f3_valid;
        end
        if (w_rdy4) begin
            r_f4_b <= r_f3_b;
            r_f4_c <= r_f3_c;
            r_f4_t <= r_f3_t;
            r_f4_a <= r_f3_pa - r_f3_pb;
        end
    end

    // ---------------- element register and entry sequencer ----------------
    logic signed [DIFF_W-1:0] r_el_b [3];
    logic signed [DIFF_W-1:0] r_el_c [3];
    t_elem                    r_el_elem;
    logic                     r_el_degen;
    logic [PROD_W-1:0]        w_amag;

    assign w_amag = r_f4_a[PROD_W-1] ? (~r_f4_a + 1'b1) : r_f4_a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_el_valid <= 1'b0;
            r_row      <= '0;
            r_col      <= '0;
        end else if (w_en) begin
            if (w_el_take) begin
                r_el_valid <= r_f4_valid;
                r_row      <= '0;
                r_col      <= '0;
            end else if (r_col == LAST_IDX) begin
                r_row <= r_row + 1'b1;
                r_col <= r_row + 1'b1;
            end else begin
                r_col <= r_col + 1'b1;
            end
        end
        if (w_el_take) begin
            r_el_b          <= r_f4_b;
            r_el_c          <= r_f4_c;
            r_el_elem.area  <= w_amag[AREA_W-1:0];
            r_el_elem.den   <= {w_amag[AREA_W-1:0], 1'b0};
            r_el_elem.thick <= r_f4_t;
            r_el_degen      <= (w_amag[AREA_W-1:0] == '0);
        end
    end

    // operand pick: even dof takes (b, c), odd dof takes (c, b)
    logic signed [DIFF_W-1:0] w_rb, w_rc, w_cb, w_cc;
    logic signed [DIFF_W-1:0] w_ui, w_si, w_uj, w_sj;

    always_comb begin
        case (r_row[2:1])
            2'd0:    begin w_rb = r_el_b[0]; w_rc = r_el_c[0]; end
            2'd1:    begin w_rb = r_el_b[1]; w_rc = r_el_c[1]; end
            default: begin w_rb = r_el_b[2]; w_rc = r_el_c[2]; end
        endcase
        case (r_col[2:1])
            2'd0:    begin w_cb = r_el_b[0]; w_cc = r_el_c[0]; end
            2'd1:    begin w_cb = r_el_b[1]; w_cc = r_el_c[1]; end
            default: begin w_cb = r_el_b[2]; w_cc = r_el_c[2]; end
        endcase
        w_ui = r_row[0] ? w_rc : w_rb;
        w_si = r_row[0] ? w_rb : w_rc;
        w_uj = r_col[0] ? w_cc : w_cb;
        w_sj = r_col[0] ? w_cb : w_cc;
    end

    // ---------------- E1: difference products ----------------
    t_ctl                     r_e1_ctl;
    t_elem                    r_e1_elem;
    logic signed [PROD_W-1:0] r_e1_pu, r_e1_ps;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e1_ctl <= '0;
        end else if (w_en) begin
            r_e1_ctl.valid <= r_el_valid;
            r_e1_ctl.row   <= r_row;
            r_e1_ctl.col   <= r_col;
            r_e1_ctl.last  <= w_last_emit;
            r_e1_ctl.degen <= r_el_degen;
        end
        if (w_en) begin
            r_e1_elem <= r_el_elem;
            r_e1_pu   <= w_ui * w_uj;
            r_e1_ps   <= w_si * w_sj;
        end
    end

    // ---------------- E2: times D, split in two halves ----------------
    logic signed [COORD_W-1:0] w_dn;
    logic signed [33:0]        w_pu_lo, w_ps_lo;
    logic signed [32:0]        w_pu_hi, w_ps_hi;
    t_ctl                      r_e2_ctl;
    t_elem                     r_e2_elem;
    logic signed [65:0]        r_e2_ul, r_e2_uh, r_e2_sl, r_e2_sh;

    always_comb begin
        if (!r_e1_ctl.row[0] && !r_e1_ctl.col[0]) begin
            w_dn = r_d_xx;
        end else if (r_e1_ctl.row[0] && r_e1_ctl.col[0]) begin
            w_dn = r_d_yy;
        end else begin
            w_dn = r_d_xy;
        end
        w_pu_lo = $signed({1'b0, r_e1_pu[32:0]});
        w_ps_lo = $signed({1'b0, r_e1_ps[32:0]});
        w_pu_hi = r_e1_pu[65:33];
        w_ps_hi = r_e1_ps[65:33];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e2_ctl <= '0;
        end else if (w_en) begin
            r_e2_ctl <= r_e1_ctl;
        end
        if (w_en) begin
            r_e2_elem <= r_e1_elem;
            r_e2_ul   <= w_pu_lo * w_dn;
            r_e2_uh   <= w_pu_hi * w_dn;
            r_e2_sl   <= w_ps_lo * r_d_shear;
            r_e2_sh   <= w_ps_hi * r_d_shear;
        end
    end

    // ---------------- E3: rejoin halves ----------------
    logic signed [SUM_W-1:0] w_ul_x, w_uh_x, w_sl_x, w_sh_x;
    t_ctl                    r_e3_ctl;
    t_elem                   r_e3_elem;
    logic signed [SUM_W-1:0] r_e3_tu, r_e3_ts;

    always_comb begin
        w_ul_x = {{(SUM_W-66){r_e2_ul[65]}}, r_e2_ul};
        w_uh_x = {{(SUM_W-66){r_e2_uh[65]}}, r_e2_uh};
        w_sl_x = {{(SUM_W-66){r_e2_sl[65]}}, r_e2_sl};
        w_sh_x = {{(SUM_W-66){r_e2_sh[65]}}, r_e2_sh};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e3_ctl <= '0;
        end else if (w_en) begin
            r_e3_ctl <= r_e2_ctl;
        end
        if (w_en) begin
            r_e3_elem <= r_e2_elem;
            r_e3_tu   <= (w_uh_x <<< 33) + w_ul_x;
            r_e3_ts   <= (w_sh_x <<< 33) + w_sl_x;
        end
    end

    // ---------------- E4: normal plus shear part ----------------
    t_ctl                    r_e4_ctl;
    t_elem                   r_e4_elem;
    logic signed [SUM_W-1:0] r_e4_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e4_ctl <= '0;
        end else if (w_en) begin
            r_e4_ctl <= r_e3_ctl;
        end
        if (w_en) begin
            r_e4_elem <= r_e3_elem;
            r_e4_n    <= r_e3_tu + r_e3_ts;
        end
    end

    // ---------------- E5: sign and magnitude ----------------
    logic [SUM_W-1:0] w_nabs;
    t_ctl             r_e5_ctl;
    t_elem            r_e5_elem;
    logic             r_e5_neg;
    logic [MAG_W-1:0] r_e5_mag;

    assign w_nabs = r_e4_n[SUM_W-1] ? (~r_e4_n + 1'b1) : r_e4_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e5_ctl <= '0;
        end else if (w_en) begin
            r_e5_ctl <= r_e4_ctl;
        end
        if (w_en) begin
            r_e5_elem <= r_e4_elem;
            r_e5_neg  <= r_e4_n[SUM_W-1];
            r_e5_mag  <= w_nabs[MAG_W-1:0];
        end
    end

    // ---------------- E6: times thickness, three slices ----------------
    t_ctl        r_e6_ctl;
    t_elem       r_e6_elem;
    logic        r_e6_neg;
    logic [63:0] r_e6_m0, r_e6_m1, r_e6_m2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e6_ctl <= '0;
        end else if (w_en) begin
            r_e6_ctl <= r_e5_ctl;
        end
        if (w_en) begin
            r_e6_elem <= r_e5_elem;
            r_e6_neg  <= r_e5_neg;
            r_e6_m0   <= r_e5_mag[32:0]  * r_e5_elem.thick;
            r_e6_m1   <= r_e5_mag[65:33] * r_e5_elem.thick;
            r_e6_m2   <= r_e5_mag[98:66] * r_e5_elem.thick;
        end
    end

    // ---------------- E7: join lower slices ----------------
    t_ctl             r_e7_ctl;
    t_elem            r_e7_elem;
    logic             r_e7_neg;
    logic [NUM_W-1:0] r_e7_s;
    logic [63:0]      r_e7_m2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e7_ctl <= '0;
        end else if (w_en) begin
            r_e7_ctl <= r_e6_ctl;
        end
        if (w_en) begin
            r_e7_elem <= r_e6_elem;
            r_e7_neg  <= r_e6_neg;
            r_e7_s    <= (NUM_W'(r_e6_m1) << 33) + NUM_W'(r_e6_m0);
            r_e7_m2   <= r_e6_m2;
        end
    end

    // ---------------- E8: top slice plus rounding offset |2A| ----------------
    t_ctl             r_e8_ctl;
    t_elem            r_e8_elem;
    logic             r_e8_neg;
    logic [NUM_W-1:0] r_e8_num;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e8_ctl <= '0;
        end else if (w_en) begin
            r_e8_ctl <= r_e7_ctl;
        end
        if (w_en) begin
            r_e8_elem <= r_e7_elem;
            r_e8_neg  <= r_e7_neg;
            r_e8_num  <= r_e7_s + (NUM_W'(r_e7_m2) << 66) + NUM_W'(r_e7_elem.area);
        end
    end

    // ---------------- divider: overflow test then one bit per stage ----------
    t_ctl             r_dv_ctl [Q_W+1];
    logic             r_dv_neg [Q_W+1];
    logic             r_dv_ovf [Q_W+1];
    logic [DEN_W-1:0] r_dv_den [Q_W+1];
    logic [DEN_W-1:0] r_dv_rem [Q_W+1];
    logic [Q_W-1:0]   r_dv_low [Q_W+1];
    logic [Q_W-1:0]   r_dv_q   [Q_W+1];

    // entry stage: quotient of 2^64 or more saturates
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_ctl[0] <= '0;
        end else if (w_en) begin
            r_dv_ctl[0] <= r_e8_ctl;
        end
        if (w_en) begin
            r_dv_neg[0] <= r_e8_neg;
            r_dv_ovf[0] <= (r_e8_num[NUM_W-1:Q_W] >= {1'b0, r_e8_elem.den});
            r_dv_den[0] <= r_e8_elem.den;
            r_dv_rem[0] <= r_e8_num[Q_W+DEN_W-1:Q_W];
            r_dv_low[0] <= r_e8_num[Q_W-1:0];
            r_dv_q[0]   <= '0;
        end
    end

    for (genvar k = 0; k < Q_W; k++) begin : g_div
        logic [DEN_W:0] w_trial, w_diff;
        logic           w_ge;

        // restoring step
        always_comb begin
            w_trial = {r_dv_rem[k], r_dv_low[k][Q_W-1]};
            w_diff  = w_trial - {1'b0, r_dv_den[k]};
            w_ge    = (w_trial >= {1'b0, r_dv_den[k]});
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_ctl[k+1] <= '0;
            end else if (w_en) begin
                r_dv_ctl[k+1] <= r_dv_ctl[k];
            end
            if (w_en) begin
                r_dv_neg[k+1] <= r_dv_neg[k];
                r_dv_ovf[k+1] <= r_dv_ovf[k];
                r_dv_den[k+1] <= r_dv_den[k];
                r_dv_rem[k+1] <= w_ge ? w_diff[DEN_W-1:0] : w_trial[DEN_W-1:0];
                r_dv_low[k+1] <= {r_dv_low[k][Q_W-2:0], 1'b0};
                r_dv_q[k+1]   <= {r_dv_q[k][Q_W-2:0], w_ge};
            end
        end
    end

    // ---------------- saturation and output register ----------------
    logic [Q_W-1:0]   w_q, w_val;
    logic [IDX_W-1:0] r_out_row, r_out_col;
    logic [Q_W-1:0]   r_out_val;
    logic             r_out_degen, r_out_last;

    assign w_q = r_dv_q[Q_W];

    always_comb begin
        if (r_dv_ctl[Q_W].degen) begin
            w_val = '0;
        end else if (r_dv_ovf[Q_W]) begin
            w_val = r_dv_neg[Q_W] ? VAL_MIN : VAL_MAX;
        end else if (!r_dv_neg[Q_W]) begin
            w_val = w_q[Q_W-1] ? VAL_MAX : w_q;
        end else if (w_q[Q_W-1] && (w_q[Q_W-2:0] != '0)) begin
            w_val = VAL_MIN;
        end else begin
            w_val = ~w_q + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= r_dv_ctl[Q_W].valid;
        end
        if (w_en) begin
            r_out_row   <= r_dv_ctl[Q_W].row;
            r_out_col   <= r_dv_ctl[Q_W].col;
            r_out_last  <= r_dv_ctl[Q_W].last;
            r_out_degen <= r_dv_ctl[Q_W].degen;
            r_out_val   <= w_val;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {2'b00, r_out_val, r_out_col, r_out_row};
    assign o_m_tuser  = r_out_degen;
    assign o_m_tlast  = r_out_last;

`ifndef SYNTHESIS
    // a degenerate element gives zero entries
    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_degen |-> r_out_val == '0)
        else $error("degenerate entry with nonzero value");

    // only the upper triangle is emitted
    a_upper: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_out_col >= r_out_row && r_out_col <= LAST_IDX)
        else $error("entry outside upper triangle");

    // the frame closes on the corner entry
    a_last_corner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_last |-> r_out_row == LAST_IDX && r_out_col == LAST_IDX)
        else $error("last entry not at (5,5)");

    // sequencer stays on or above the diagonal
    a_seq_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_el_valid |-> r_col >= r_row && r_row <= LAST_IDX)
        else $error("sequencer index out of range");
`endif

endmodule

`default_nettype wire

// File: tb/tb_cst_triangle_stiffness.sv
// ---------------------------------------------------------------------------
// tb_cst_triangle_stiffness
// Self-checking bench for the triangle stiffness block. Each accepted
// element is expanded into its 21 upper-triangle stiffness entries by a
// local exact-integer predictor; the result stream is compared entry by
// entry. Random idles on both ports, a long result hold-off and a drain.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_cst_triangle_stiffness;
    import cstk_pkg::*;

    typedef struct {
        logic [2:0]  row;
        logic [2:0]  col;
        logic [63:0] val;
        logic        degen;
        logic        last;
    } t_entry;

    class stiffness_board;
        logic signed [31:0] dxx, dxy, dyy, dsh;
        t_entry pending[$];
        int     errors;

        function new();
            dxx = RST_D_XX; dxy = RST_D_XY; dyy = RST_D_YY; dsh = RST_D_SHEAR;
            errors = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [31:0] v);
            case (idx)
                CFG_D_XX:    dxx = v;
                CFG_D_XY:    dxy = v;
                CFG_D_YY:    dyy = v;
                CFG_D_SHEAR: dsh = v;
                default: ;
            endcase
        endfunction

        // expand one element into its 21 expected entries
        function void note_element(logic [223:0] d);
            logic signed [33:0]  x[3], y[3], b[3], c[3];
            logic signed [33:0]  t;
            logic signed [159:0] area2, acc, ui, si, uj, sj, dn;
            logic        [159:0] mag, den, q;
            logic                degen, neg;
            t_entry              e;
            int                  k;
            k = 0;
            for (int n = 0; n < 3; n++) begin
                x[n] = $signed(d[64*n +: 32]);
                y[n] = $signed(d[64*n+32 +: 32]);
            end
            t = $signed(d[192 +: 32]);
            if (t <= 0) t = 65536;
            for (int n = 0; n < 3; n++) begin
                b[n] = y[(n+1)%3] - y[(n+2)%3];
                c[n] = x[(n+2)%3] - x[(n+1)%3];
            end
            area2 = 160'(x[1]-x[0]) * 160'(y[2]-y[0]) - 160'(x[2]-x[0]) * 160'(y[1]-y[0]);
            if (area2 < 0) area2 = -area2;
            degen = (area2 == 0);
            den = 2 * area2;
            for (int i = 0; i < 6; i++) begin
                for (int j = i; j < 6; j++) begin
                    e.row = i; e.col = j; e.degen = degen; e.last = (k == 20);
                    e.val = '0;
                    if (!degen) begin
                        ui = (i & 1) ? c[i>>1] : b[i>>1];
                        si = (i & 1) ? b[i>>1] : c[i>>1];
                        uj = (j & 1) ? c[j>>1] : b[j>>1];
                        sj = (j & 1) ? b[j>>1] : c[j>>1];
                        dn = (!(i & 1) && !(j & 1)) ? 160'(dxx)
                           : ((i & 1) && (j & 1)) ? 160'(dyy) : 160'(dxy);
                        acc = ui * dn * uj + si * 160'(dsh) * sj;
                        neg = acc < 0;
                        mag = neg ? -acc : acc;
                        // round half away from zero
                        q = (mag * 160'(t) + 160'(area2)) / den;
                        if (!neg) e.val = (q > 160'h7FFF_FFFF_FFFF_FFFF) ? VAL_MAX : q[63:0];
                        else e.val = (q > 160'h8000_0000_0000_0000) ? VAL_MIN : -q[63:0];
                    end
                    pending.push_back(e);
                    k++;
                end
            end
        endfunction

        function void check_entry(t_entry got);
            t_entry want;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected entry row %0d col %0d val %h",
                             got.row, got.col, got.val);
                return;
            end
            want = pending.pop_front();
            if (got.row !== want.row || got.col !== want.col || got.val !== want.val ||
                got.degen !== want.degen || got.last !== want.last) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch exp r%0d c%0d %h d%b l%b got r%0d c%0d %h d%b l%b",
                             want.row, want.col, want.val, want.degen, want.last,
                             got.row, got.col, got.val, got.degen, got.last);
            end
        endfunction
    endclass

    logic         i_clk = 0;
    logic         i_rst_n = 0;
    logic         i_s_tvalid = 0;
    logic         o_s_tready;
    logic [223:0] i_s_tdata = '0;
    logic         o_m_tvalid;
    logic         i_m_tready = 0;
    logic [71:0]  o_m_tdata;
    logic         o_m_tuser, o_m_tlast;
    logic         i_cfg_we = 0;
    logic [1:0]   i_cfg_idx = '0;
    logic [31:0]  i_cfg_data = '0;

    stiffness_board board = new();
    int  hold_cycles = 0;   // long receiver hold-off when nonzero
    bit  sink_busy = 1;     // random sink idles enabled

    cst_triangle_stiffness u_dut (.*);

    always #5 i_clk = ~i_clk;

    // watchdog
    initial begin
        #40ms;
        $display("Simulation FAILED");
        $finish;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // result sink: random stalls plus optional long hold-off
    always @(posedge i_clk) begin
        t_entry got;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got.row = o_m_tdata[2:0]; got.col = o_m_tdata[5:3];
            got.val = o_m_tdata[69:6]; got.degen = o_m_tuser; got.last = o_m_tlast;
            board.check_entry(got);
        end
    end

    initial begin
        int g;
        @(negedge i_clk);
        forever begin
            if (hold_cycles > 0) begin
                i_m_tready <= 0;
                repeat (hold_cycles) @(negedge i_clk);
                hold_cycles = 0;
            end
            g = sink_busy ? gap_len() : 0;
            if (g > 0) begin
                i_m_tready <= 0;
                repeat (g) @(negedge i_clk);
            end
            i_m_tready <= 1;
            @(negedge i_clk);
        end
    end

    // leaves tvalid high; the next gap or the drain lowers it
    task automatic send_element(logic [223:0] d);
        int g;
        g = gap_len();
        if (g > 0) begin
            i_s_tvalid <= 0;
            repeat (g) @(negedge i_clk);
        end
        i_s_tvalid <= 1;
        i_s_tdata  <= d;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        board.note_element(d);
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_s_tvalid <= 0;
        while (board.pending.size() != 0) @(negedge i_clk);
        repeat (100) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] v);
        i_cfg_we <= 1; i_cfg_idx <= idx; i_cfg_data <= v;
        @(negedge i_clk);
        i_cfg_we <= 0;
        board.write_reg(idx, v);
        @(negedge i_clk);
    endtask

    function automatic logic [31:0] rnd_word(int mode);
        case (mode)
            0: return $urandom();
            1: return $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000;
            default: return $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000;
        endcase
    endfunction

    function automatic logic [223:0] rnd_element();
        logic [223:0] d;
        int mode, r;
        mode = $urandom_range(0, 2);
        for (int n = 0; n < 7; n++) d[32*n +: 32] = rnd_word(mode);
        r = $urandom_range(0, 9);
        if (r == 0) d[128 +: 64] = d[0 +: 64];                 // repeated node
        else if (r == 1) d[192 +: 32] = -$urandom_range(0, 1000); // repaired thickness
        return d;
    endfunction

    function automatic logic [223:0] mk_elem(int x1, int y1, int x2, int y2, int x3, int y3,
                                             int t);
        return {t[31:0], y3[31:0], x3[31:0], y2[31:0], x2[31:0], y1[31:0], x1[31:0]};
    endfunction

    initial begin
        logic [31:0] dset[4];
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);

        // directed: default D, basic shapes and corner cases
        send_element(mk_elem(0, 0, 65536, 0, 0, 65536, 65536));
        send_element(mk_elem(0, 0, 0, 65536, 65536, 0, 65536));        // clockwise
        send_element(mk_elem(0, 0, 65536, 65536, 131072, 131072, 65536)); // collinear
        send_element(mk_elem(5, 5, 5, 5, 5, 5, 0));                     // all same
        send_element(mk_elem(0, 0, 65536, 0, 0, 65536, 0));             // zero thickness
        send_element(mk_elem(0, 0, 65536, 0, 0, 65536, 32'h8000_0000)); // most negative
        send_element(mk_elem(0, 0, 65536, 0, 0, 65536, 32'h7FFF_FFFF));
        send_element(mk_elem(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                             32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        send_element(mk_elem(0, 0, 1, 0, 0, 1, 32'h7FFF_FFFF));       // tiny area
        send_element(mk_elem(32'h7FFF_FFFF, 0, 32'h8000_0000, 1, 0, 32'h8000_0000, 1));
        send_element({224{1'b1}});
        send_element(mk_elem(3, 7, -11, 2, 9, -4, 3));                  // rounding ties region
        drain();

        // extreme D values
        write_reg(CFG_D_XX, 32'h7FFF_FFFF);
        write_reg(CFG_D_XY, 32'h8000_0000);
        write_reg(CFG_D_YY, 32'h8000_0000);
        write_reg(CFG_D_SHEAR, 32'h7FFF_FFFF);
        send_element(mk_elem(0, 0, 1, 0, 0, 1, 32'h7FFF_FFFF));
        send_element(mk_elem(0, 0, 65536, 0, 0, 65536, 65536));
        send_element(mk_elem(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                             32'h8000_0000, 32'h7FFF_FFFF, 1));
        drain();

        // random phases, each with its own D
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: dset = '{32'h000A_0000, 32'h0003_0000, 32'h000A_0000, 32'h0003_8000};
                1: dset = '{0, 0, 0, 0};
                2: dset = '{32'hFFFF_0000, 32'h7FFF_FFFF, 32'h0000_0001, 32'h8000_0000};
                default: dset = '{$urandom(), $urandom(), $urandom(), $urandom()};
            endcase
            for (int r = 0; r < 4; r++) write_reg(r[1:0], dset[r]);
            if (ph == 2) hold_cycles = 400;     // block backs up, input stalls
            sink_busy = (ph != 4);
            for (int n = 0; n < 42; n++) send_element(rnd_element());
            drain();                            // sender waits for everything
        end

        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
